// ===== design/ptd_pkg.sv =====
// Shared types and constants of the periodic task dispatcher.
// No dependencies; every other design file imports this package.
package ptd_pkg;

  // Table geometry
  localparam int TASK_SLOTS = 8;
  localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

  // Fixed field widths
  localparam int FUNC_W   = 2;
  localparam int TICK_W   = 32;
  localparam int TASK_W   = 3;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 4;

  // Request function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_REGISTER = 2'd0,
    FUNC_START    = 2'd1,
    FUNC_DISPATCH = 2'd2,
    FUNC_REPORT   = 2'd3
  } ptd_func_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_TASK = 2'd2
  } ptd_status_e;

  // Datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LATCH,
    OP_REGISTER,
    OP_START,
    OP_REPORT,
    OP_SCAN,
    OP_EMIT_DUE,
    OP_EMIT_IDLE
  } ptd_op_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SINGLE,
    S_SCAN,
    S_EMIT
  } ptd_state_e;

  typedef struct packed {
    ptd_op_e op;
  } ptd_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              running;
    logic              scan_done;
    logic              mask_empty;
    logic              mask_one;
    logic              out_free;
  } ptd_stat_t;

endpackage

// ===== design/ptd_req_if.sv =====
// Request channel of the dispatcher: valid/ready plus the request fields.
// Depends on ptd_pkg for field widths.
interface ptd_req_if;
  import ptd_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [TICK_W-1:0] period_ticks;
  logic [TICK_W-1:0] now_tick;
  logic [TASK_W-1:0] report_task;
  logic [TICK_W-1:0] exec_ticks;

  modport source (
    output valid, func, period_ticks, now_tick, report_task, exec_ticks,
    input  ready
  );
  modport sink (
    input  valid, func, period_ticks, now_tick, report_task, exec_ticks,
    output ready
  );
endinterface

// ===== design/ptd_rsp_if.sv =====
// Result channel of the dispatcher: valid/ready plus the result fields.
// Depends on ptd_pkg for field widths.
interface ptd_rsp_if;
  import ptd_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                due_valid;
  logic [TASK_W-1:0]   due_task;
  logic                last_of_run;
  logic [TOTAL_W-1:0]  task_total;
  logic                any_overrun;
  logic [TICK_W-1:0]   task_overruns;
  logic [TICK_W-1:0]   task_max_exec;

  modport source (
    output valid, status, due_valid, due_task, last_of_run, task_total,
           any_overrun, task_overruns, task_max_exec,
    input  ready
  );
  modport sink (
    input  valid, status, due_valid, due_task, last_of_run, task_total,
           any_overrun, task_overruns, task_max_exec,
    output ready
  );
endinterface

// ===== design/ptd_ctrl.sv =====
// Controller state machine of the dispatcher: sequences one request at a time.
// Depends on ptd_pkg; drives ptd_dp through the command struct.
module ptd_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [ptd_pkg::FUNC_W-1:0] in_func_i,
  output logic                      in_ready_o,
  input  ptd_pkg::ptd_stat_t        stat_i,
  output ptd_pkg::ptd_cmd_t         cmd_o
);
  import ptd_pkg::*;

  ptd_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          case (in_func_i)
            FUNC_DISPATCH: state_d = stat_i.running ? S_SCAN : S_EMIT;
            default:       state_d = S_SINGLE;
          endcase
        end
      end
      S_SINGLE: begin
        if (stat_i.out_free) begin
          case (stat_i.func)
            FUNC_REGISTER: cmd_o.op = OP_REGISTER;
            FUNC_START:    cmd_o.op = OP_START;
            default:       cmd_o.op = OP_REPORT;
          endcase
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        // one table entry per cycle
        if (stat_i.scan_done) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.op = OP_SCAN;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          if (stat_i.mask_empty) begin
            cmd_o.op = OP_EMIT_IDLE;
            state_d  = S_IDLE;
          end else begin
            cmd_o.op = OP_EMIT_DUE;
            if (stat_i.mask_one) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // A result is loaded only into a free output register
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_REGISTER || cmd_o.op == OP_START || cmd_o.op == OP_REPORT ||
     cmd_o.op == OP_EMIT_DUE || cmd_o.op == OP_EMIT_IDLE) |-> stat_i.out_free)
    else $error("result loaded while output register busy");

  // A due result needs a pending due task
  a_due_has_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_EMIT_DUE) |-> !stat_i.mask_empty)
    else $error("due result with empty due mask");

  // Idle is left only on an accepted request
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !in_valid_i) |=> (state_q == S_IDLE))
    else $error("left idle without a request");

endmodule

// ===== design/ptd_dp.sv =====
// Datapath of the dispatcher: task tables, counters, due mask, result register.
// Depends on ptd_pkg; controlled by ptd_ctrl through the command struct.
module ptd_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptd_pkg::ptd_cmd_t            cmd_i,
  output ptd_pkg::ptd_stat_t           stat_o,
  input  logic [ptd_pkg::FUNC_W-1:0]   in_func_i,
  input  logic [ptd_pkg::TICK_W-1:0]   in_period_ticks_i,
  input  logic [ptd_pkg::TICK_W-1:0]   in_now_tick_i,
  input  logic [ptd_pkg::TASK_W-1:0]   in_report_task_i,
  input  logic [ptd_pkg::TICK_W-1:0]   in_exec_ticks_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [ptd_pkg::STATUS_W-1:0] out_status_o,
  output logic                         out_due_valid_o,
  output logic [ptd_pkg::TASK_W-1:0]   out_due_task_o,
  output logic                         out_last_of_run_o,
  output logic [ptd_pkg::TOTAL_W-1:0]  out_task_total_o,
  output logic                         out_any_overrun_o,
  output logic [ptd_pkg::TICK_W-1:0]   out_task_overruns_o,
  output logic [ptd_pkg::TICK_W-1:0]   out_task_max_exec_o
);
  import ptd_pkg::*;

  localparam int RCMP_W = TASK_W + CNT_W;

  // Latched request
  logic [FUNC_W-1:0] func_q;
  logic [TICK_W-1:0] period_q, now_q, exec_q;
  logic [TASK_W-1:0] rtask_q;

  // Task tables
  logic [TICK_W-1:0] period_mem  [TASK_SLOTS];
  logic [TICK_W-1:0] lastrun_mem [TASK_SLOTS];
  logic [TICK_W-1:0] ovr_mem     [TASK_SLOTS];
  logic [TICK_W-1:0] maxex_mem   [TASK_SLOTS];

  // Control state
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  running_q, running_d;
  logic [TASK_SLOTS-1:0] ovr_nz_q, ovr_nz_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [TASK_SLOTS-1:0] mask_q, mask_d;
  logic                  out_valid_q;

  // Result payload
  logic [STATUS_W-1:0] out_status_q;
  logic                out_due_valid_q, out_last_q, out_any_q;
  logic [TASK_W-1:0]   out_task_q;
  logic [TOTAL_W-1:0]  out_total_q;
  logic [TICK_W-1:0]   out_ovr_q, out_max_q;

  // Combinational helpers
  logic [TASK_SLOTS-1:0] reg_mask;
  logic                  full, rpt_ok, due, over, mask_one;
  logic [IDX_W-1:0]      cnt_idx, scan_idx, rpt_idx, rd_idx, sel;
  logic [TICK_W-1:0]     rd_period, rd_lastrun, rd_ovr, rd_max;
  logic [TICK_W-1:0]     ovr_new, max_new;

  // Table write controls
  logic                  per_we, om_we;
  logic [IDX_W-1:0]      wa;
  logic [TICK_W-1:0]     ovr_wd, max_wd;
  logic [TASK_SLOTS-1:0] lr_we;
  logic [TICK_W-1:0]     lr_wd;

  // Result load
  logic                load;
  ptd_status_e         ld_status;
  logic                ld_due_valid, ld_last;
  logic [IDX_W-1:0]    ld_task;
  logic [TICK_W-1:0]   ld_ovr, ld_max;

  // Registered-slot mask and indexes
  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      reg_mask[i] = (CNT_W'(i) < count_q);
    end
  end

  assign full     = (count_q >= CNT_W'(TASK_SLOTS));
  assign cnt_idx  = count_q[IDX_W-1:0];
  assign scan_idx = idx_q[IDX_W-1:0];
  assign rpt_idx  = IDX_W'(rtask_q);
  assign rpt_ok   = (RCMP_W'(rtask_q) < RCMP_W'(count_q));
  assign rd_idx   = (cmd_i.op == OP_REPORT) ? rpt_idx : scan_idx;

  // Table reads at one address
  assign rd_period  = period_mem[rd_idx];
  assign rd_lastrun = lastrun_mem[rd_idx];
  assign rd_ovr     = ovr_mem[rd_idx];
  assign rd_max     = maxex_mem[rd_idx];

  // Due test with wrapping tick difference
  assign due = ((now_q - rd_lastrun) >= rd_period);

  // Completion update: saturating overrun count and running maximum
  assign over    = (exec_q > rd_period);
  assign ovr_new = (over && (rd_ovr != '1)) ? rd_ovr + 1'b1 : rd_ovr;
  assign max_new = (exec_q > rd_max) ? exec_q : rd_max;

  // Lowest pending due task
  always_comb begin
    sel = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel = IDX_W'(i);
      end
    end
  end

  assign mask_one = (mask_q != '0) && ((mask_q & (mask_q - 1'b1)) == '0);

  // Operation decode
  always_comb begin
    count_d      = count_q;
    running_d    = running_q;
    ovr_nz_d     = ovr_nz_q;
    idx_d        = idx_q;
    mask_d       = mask_q;
    per_we       = 1'b0;
    om_we        = 1'b0;
    wa           = cnt_idx;
    ovr_wd       = '0;
    max_wd       = '0;
    lr_we        = '0;
    lr_wd        = now_q;
    load         = 1'b0;
    ld_status    = STATUS_OK;
    ld_due_valid = 1'b0;
    ld_task      = '0;
    ld_last      = 1'b1;
    ld_ovr       = '0;
    ld_max       = '0;
    case (cmd_i.op)
      OP_LATCH: begin
        idx_d  = '0;
        mask_d = '0;
      end
      OP_REGISTER: begin
        load = 1'b1;
        if (full) begin
          ld_status = STATUS_FULL;
        end else begin
          per_we            = 1'b1;
          om_we             = 1'b1;
          lr_we[cnt_idx]    = 1'b1;
          lr_wd             = '0;
          ovr_nz_d[cnt_idx] = 1'b0;
          count_d           = count_q + 1'b1;
        end
      end
      OP_START: begin
        load      = 1'b1;
        lr_we     = reg_mask;
        running_d = 1'b1;
      end
      OP_REPORT: begin
        load = 1'b1;
        if (rpt_ok) begin
          om_we             = 1'b1;
          wa                = rpt_idx;
          ovr_wd            = ovr_new;
          max_wd            = max_new;
          ovr_nz_d[rpt_idx] = (ovr_new != '0);
          ld_ovr            = ovr_new;
          ld_max            = max_new;
        end else begin
          ld_status = STATUS_BAD_TASK;
        end
      end
      OP_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (due) begin
          mask_d[scan_idx] = 1'b1;
          lr_we[scan_idx]  = 1'b1;
        end
      end
      OP_EMIT_DUE: begin
        load         = 1'b1;
        ld_due_valid = 1'b1;
        ld_task      = sel;
        ld_last      = mask_one;
        mask_d[sel]  = 1'b0;
      end
      OP_EMIT_IDLE: begin
        load = 1'b1;
      end
      default: ;
    endcase
  end

  // Task tables (contents defined once a task registers)
  always_ff @(posedge clk_i) begin
    if (per_we) begin
      period_mem[wa] <= period_q;
    end
    if (om_we) begin
      ovr_mem[wa]   <= ovr_wd;
      maxex_mem[wa] <= max_wd;
    end
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (lr_we[i]) begin
        lastrun_mem[i] <= lr_wd;
      end
    end
  end

  // Request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      func_q   <= in_func_i;
      period_q <= in_period_ticks_i;
      now_q    <= in_now_tick_i;
      rtask_q  <= in_report_task_i;
      exec_q   <= in_exec_ticks_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      running_q   <= 1'b0;
      ovr_nz_q    <= '0;
      idx_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      running_q <= running_d;
      ovr_nz_q  <= ovr_nz_d;
      idx_q     <= idx_d;
      mask_q    <= mask_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q    <= ld_status;
      out_due_valid_q <= ld_due_valid;
      out_task_q      <= TASK_W'(ld_task);
      out_last_q      <= ld_last;
      out_total_q     <= TOTAL_W'(count_d);
      out_any_q       <= |ovr_nz_d;
      out_ovr_q       <= ld_ovr;
      out_max_q       <= ld_max;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_due_valid_o     = out_due_valid_q;
  assign out_due_task_o      = out_task_q;
  assign out_last_of_run_o   = out_last_q;
  assign out_task_total_o    = out_total_q;
  assign out_any_overrun_o   = out_any_q;
  assign out_task_overruns_o = out_ovr_q;
  assign out_task_max_exec_o = out_max_q;

  // Status to the controller
  assign stat_o.func       = func_q;
  assign stat_o.running    = running_q;
  assign stat_o.scan_done  = (idx_q >= count_q);
  assign stat_o.mask_empty = (mask_q == '0);
  assign stat_o.mask_one   = mask_one;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Task count stays within the table
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TASK_SLOTS))
    else $error("task count beyond table size");

  // Overrun flags only on registered slots
  a_flags_registered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovr_nz_q & ~reg_mask) == '0)
    else $error("overrun flag on unregistered slot");

  // Due results only once dispatch is enabled
  a_due_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_due_valid_q) |-> running_q)
    else $error("due result while not running");

endmodule

// ===== design/periodic_task_dispatcher.sv =====
// Top level of the periodic task dispatcher: controller plus datapath.
// Depends on ptd_pkg, ptd_req_if, ptd_rsp_if, ptd_ctrl and ptd_dp.
//
// Usage: requests arrive on req_i (valid/ready). func selects register task,
// start, dispatch tick or completion report. Results leave on rsp_o through
// a single output register; a request is taken whenever the controller is
// idle, even while the previous result still waits to be taken.
// Register, start and report requests give one result each, loaded once the
// output register is free. Once started, a dispatch request scans the table
// one entry per cycle and then emits one result per due task, one per cycle
// while rsp_o is not stalled, the final one flagged with last_of_run; with no
// due task, or before start, it gives one result without a due task. The
// next request is accepted the cycle after the last result is loaded. The
// scan loop over the table sets the dispatch time; the output register the rest.
// Reset clears the task count, the run flag and the overrun flags; table
// contents are written when a task registers. When rsp_o is stalled the
// output register holds its result and the block waits before loading the
// next one; nothing is dropped.
module periodic_task_dispatcher (
  input logic      clk_i,
  input logic      rst_ni,
  ptd_req_if.sink  req_i,
  ptd_rsp_if.source rsp_o
);
  import ptd_pkg::*;

  ptd_cmd_t  cmd;
  ptd_stat_t stat;
  logic      in_ready;

  assign req_i.ready = in_ready;

  ptd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_func_i  (req_i.func),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ptd_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .in_func_i           (req_i.func),
    .in_period_ticks_i   (req_i.period_ticks),
    .in_now_tick_i       (req_i.now_tick),
    .in_report_task_i    (req_i.report_task),
    .in_exec_ticks_i     (req_i.exec_ticks),
    .out_ready_i         (rsp_o.ready),
    .out_valid_o         (rsp_o.valid),
    .out_status_o        (rsp_o.status),
    .out_due_valid_o     (rsp_o.due_valid),
    .out_due_task_o      (rsp_o.due_task),
    .out_last_of_run_o   (rsp_o.last_of_run),
    .out_task_total_o    (rsp_o.task_total),
    .out_any_overrun_o   (rsp_o.any_overrun),
    .out_task_overruns_o (rsp_o.task_overruns),
    .out_task_max_exec_o (rsp_o.task_max_exec)
  );

endmodule
